[hdl/s2a_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2a_pkg
// Shared types, constants and key maps for the set-1 scancode translator.
// ----------------------------------------------------------------------------
package s2a_pkg;

    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int TABLE_SIZE      = 58;
    localparam int MAX_BYTES       = 4;

    localparam logic       CMD_SCAN = 1'b0;
    localparam logic       CMD_POP  = 1'b1;

    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
    localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
    localparam logic [7:0] SC_UP           = 8'h48;
    localparam logic [7:0] SC_DOWN         = 8'h50;
    localparam logic [7:0] SC_RIGHT        = 8'h4D;
    localparam logic [7:0] SC_LEFT         = 8'h4B;
    localparam logic [7:0] SC_HOME         = 8'h47;
    localparam logic [7:0] SC_END          = 8'h4F;
    localparam logic [7:0] SC_DELETE       = 8'h53;

    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [7:0] CSI_BYTE = 8'h5B;

    localparam logic [7:0] PLAIN_MAP [TABLE_SIZE] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    localparam logic [7:0] SHIFTED_MAP [TABLE_SIZE] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    typedef struct packed {
        logic            shift_held;
        logic            ctrl_held;
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } xlate_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_sts_t;

endpackage

[hdl/s2a_xlate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2a_xlate
// Decodes one scancode into modifier updates and up to four queue bytes.
// ----------------------------------------------------------------------------
module s2a_xlate (
    input  logic [7:0]      scan_byte,
    input  logic            shift_held,
    input  logic            ctrl_held,
    output s2a_pkg::xlate_t xlate
);
    import s2a_pkg::*;

    logic [7:0] map_byte;
    logic [7:0] ctrl_byte;
    logic       is_letter;

    always_comb
    begin
        map_byte = 8'h00;
        if (scan_byte < 8'(TABLE_SIZE))
        begin
            map_byte = shift_held ? SHIFTED_MAP[scan_byte[5:0]] : PLAIN_MAP[scan_byte[5:0]];
        end
        is_letter = (map_byte >= 8'h61 && map_byte <= 8'h7A)
                 || (map_byte >= 8'h41 && map_byte <= 8'h5A);
        ctrl_byte = (ctrl_held && is_letter) ? {3'b000, map_byte[4:0]} : map_byte;
    end

    always_comb
    begin
        xlate.shift_held = shift_held;
        xlate.ctrl_held  = ctrl_held;
        xlate.bytes      = {8'h00, 8'h00, CSI_BYTE, ESC_BYTE};
        xlate.count      = 3'd0;
        unique case (scan_byte)
            SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   xlate.shift_held = 1'b1;
            SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: xlate.shift_held = 1'b0;
            SC_CTRL_MAKE:                     xlate.ctrl_held  = 1'b1;
            SC_CTRL_BREAK:                    xlate.ctrl_held  = 1'b0;
            SC_UP:
            begin
                xlate.bytes[2] = 8'h41;
                xlate.count    = 3'd3;
            end
            SC_DOWN:
            begin
                xlate.bytes[2] = 8'h42;
                xlate.count    = 3'd3;
            end
            SC_RIGHT:
            begin
                xlate.bytes[2] = 8'h43;
                xlate.count    = 3'd3;
            end
            SC_LEFT:
            begin
                xlate.bytes[2] = 8'h44;
                xlate.count    = 3'd3;
            end
            SC_HOME:
            begin
                xlate.bytes[2] = 8'h48;
                xlate.count    = 3'd3;
            end
            SC_END:
            begin
                xlate.bytes[2] = 8'h46;
                xlate.count    = 3'd3;
            end
            SC_DELETE:
            begin
                xlate.bytes[2] = 8'h33;
                xlate.bytes[3] = 8'h7E;
                xlate.count    = 3'd4;
            end
            default:
            begin
                if (!scan_byte[7] && map_byte != 8'h00)
                begin
                    xlate.bytes[0] = ctrl_byte;
                    xlate.count    = 3'd1;
                end
            end
        endcase
    end

endmodule

[hdl/s2a_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2a_fifo
// Ring buffer of bytes in a synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module s2a_fifo #(
    parameter int DEPTH = s2a_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  s2a_pkg::fifo_ctl_t  ctl,
    input  logic [7:0]          wr_data,
    output logic [7:0]          rd_data,
    output s2a_pkg::fifo_sts_t  sts
);
    import s2a_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic [7:0]       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [7:0]       rd_data_reg;

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        sts.empty   = (rd_ptr_reg == wr_ptr_reg);
        sts.full    = (wr_ptr_next == rd_ptr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (ctl.push && !sts.full)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (ctl.pop && !sts.empty)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push && !sts.full)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (ctl.pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/scancode_to_ascii_fifo_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_core
// Set-1 scancode to ASCII translator with a byte queue and a pop command.
// ----------------------------------------------------------------------------
// A transfer with tuser low carries a scancode; it updates the shift and ctrl
// flags or writes one to four bytes into the queue, one byte per cycle, and
// the block takes no new transfer until the last byte is written. A
// transfer with tuser high pops the oldest byte; the queue memory answers in
// the next cycle and the result transfer appears on the next cycle that the
// output register is free. The queue holds at most QUEUE_DEPTH-1 bytes and
// drops bytes that arrive when it is full.
module scancode_to_ascii_fifo_core #(
    parameter int QUEUE_DEPTH = s2a_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] scan_byte
    input  logic [0:0] s_axis_tuser,  // [0] command
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] char_byte
    output logic [0:0] m_axis_tuser   // [0] char_valid
);
    import s2a_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_PUSH, ST_POP} state_t;

    state_t          state_reg;
    logic            shift_reg;
    logic            ctrl_reg;
    logic [3:0][7:0] bytes_reg;
    logic [2:0]      count_reg;
    logic [1:0]      idx_reg;
    logic            empty_pop_reg;
    logic            m_tvalid_reg;
    logic [7:0]      m_tdata_reg;
    logic            m_tuser_reg;

    xlate_t          xlate;
    fifo_ctl_t       fifo_ctl;
    fifo_sts_t       fifo_sts;
    logic [7:0]      rd_data;
    logic            in_xfer;
    logic            out_free;

    s2a_xlate u_xlate (
        .scan_byte  (s_axis_tdata),
        .shift_held (shift_reg),
        .ctrl_held  (ctrl_reg),
        .xlate      (xlate)
    );

    s2a_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (fifo_ctl),
        .wr_data (bytes_reg[idx_reg]),
        .rd_data (rd_data),
        .sts     (fifo_sts)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;

    always_comb
    begin
        fifo_ctl.push = (state_reg == ST_PUSH);
        fifo_ctl.pop  = in_xfer && (s_axis_tuser[0] == CMD_POP) && !fifo_sts.empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            shift_reg     <= 1'b0;
            ctrl_reg      <= 1'b0;
            count_reg     <= 3'd0;
            idx_reg       <= 2'd0;
            empty_pop_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= 8'h00;
            m_tuser_reg   <= 1'b0;
            bytes_reg     <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_axis_tready && state_reg != ST_POP)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (s_axis_tuser[0] == CMD_POP)
                        begin
                            empty_pop_reg <= fifo_sts.empty;
                            state_reg     <= ST_POP;
                        end
                        else
                        begin
                            shift_reg <= xlate.shift_held;
                            ctrl_reg  <= xlate.ctrl_held;
                            bytes_reg <= xlate.bytes;
                            count_reg <= xlate.count;
                            idx_reg   <= 2'd0;
                            if (xlate.count != 3'd0)
                            begin
                                state_reg <= ST_PUSH;
                            end
                        end
                    end
                end
                ST_PUSH:
                begin
                    idx_reg <= idx_reg + 2'd1;
                    if ({1'b0, idx_reg} + 3'd1 == count_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_POP:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= empty_pop_reg ? 8'h00 : rd_data;
                        m_tuser_reg  <= !empty_pop_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = m_tvalid_reg;
    assign m_axis_tdata    = m_tdata_reg;
    assign m_axis_tuser[0] = m_tuser_reg;

`ifndef SYNTH
    a_push_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> ({1'b0, idx_reg} < count_reg))
        else $error("Queue write index ran past the byte count.");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tuser_reg) |-> (m_tdata_reg == 8'h00))
        else $error("Empty pop result carries a nonzero byte.");

    a_pop_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP && out_free) |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("Pop did not load the output register.");

    a_pop_frees_space: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_ctl.pop |=> !fifo_sts.full)
        else $error("Queue still full after a byte was popped.");
`endif

endmodule

[tb/scancode_to_ascii_fifo_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_checker
// Watches both streams of the scancode translator and keeps its own model of
// the key flags and the byte queue. Every accepted pop adds the character it
// should return, and every output transfer is checked against the oldest one.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_checker #(
    parameter int QUEUE_DEPTH = s2a_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] scan_byte
    input  logic [0:0] s_axis_tuser,   // [0] command
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] char_byte
    input  logic [0:0] m_axis_tuser,   // [0] char_valid
    output int         fail_count,
    output int         expected_left,
    output int         results_seen,
    output int         data_results,
    output int         dropped_bytes
);

    import s2a_pkg::*;

    localparam logic [8*TABLE_SIZE-1:0] PLAIN_KEYS = {
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    localparam logic [8*TABLE_SIZE-1:0] SHIFTED_KEYS = {
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    localparam logic [7:0] FIN_UP    = 8'h41;
    localparam logic [7:0] FIN_DOWN  = 8'h42;
    localparam logic [7:0] FIN_RIGHT = 8'h43;
    localparam logic [7:0] FIN_LEFT  = 8'h44;
    localparam logic [7:0] FIN_HOME  = 8'h48;
    localparam logic [7:0] FIN_END   = 8'h46;
    localparam logic [7:0] FIN_DEL   = 8'h33;
    localparam logic [7:0] FIN_TILDE = 8'h7E;
    localparam logic [7:0] NO_FINAL  = 8'h00;

    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       char_valid;
    } char_result_t;

    logic [7:0]   model_bytes [$];
    char_result_t pending_chars [$];
    logic         shift_on;
    logic         ctrl_on;

    function automatic logic [7:0] key_lookup(input logic [7:0] code, input logic shifted);
        int pos;
        pos = 8 * (TABLE_SIZE - 1 - int'(code));
        return shifted ? SHIFTED_KEYS[pos +: 8] : PLAIN_KEYS[pos +: 8];
    endfunction

    function void store_char(input logic [7:0] value);
        if (model_bytes.size() < QUEUE_DEPTH - 1)
            model_bytes.push_back(value);
        else
            dropped_bytes++;
    endfunction

    function void store_escape(input logic [7:0] final_a, input logic [7:0] final_b);
        store_char(ESC_BYTE);
        store_char(CSI_BYTE);
        store_char(final_a);
        if (final_b != NO_FINAL)
            store_char(final_b);
    endfunction

    function void predict_scancode(input logic [7:0] code);
        logic [7:0] ch;
        case (code)
            SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   shift_on = 1'b1;
            SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: shift_on = 1'b0;
            SC_CTRL_MAKE:                     ctrl_on = 1'b1;
            SC_CTRL_BREAK:                    ctrl_on = 1'b0;
            SC_UP:                            store_escape(FIN_UP, NO_FINAL);
            SC_DOWN:                          store_escape(FIN_DOWN, NO_FINAL);
            SC_RIGHT:                         store_escape(FIN_RIGHT, NO_FINAL);
            SC_LEFT:                          store_escape(FIN_LEFT, NO_FINAL);
            SC_HOME:                          store_escape(FIN_HOME, NO_FINAL);
            SC_END:                           store_escape(FIN_END, NO_FINAL);
            SC_DELETE:                        store_escape(FIN_DEL, FIN_TILDE);
            default:
            begin
                if (!code[7] && code < TABLE_SIZE)
                begin
                    ch = key_lookup(code, shift_on);
                    if (ch != 8'h00)
                    begin
                        if (ctrl_on && ch >= LOWER_A && ch <= LOWER_Z)
                            ch = ch - LOWER_A + 8'd1;
                        else if (ctrl_on && ch >= UPPER_A && ch <= UPPER_Z)
                            ch = ch - UPPER_A + 8'd1;
                        store_char(ch);
                    end
                end
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        char_result_t got;
        char_result_t want;
        if (!rst_n)
        begin
            model_bytes.delete();
            pending_chars.delete();
            shift_on = 1'b0;
            ctrl_on = 1'b0;
            fail_count = 0;
            expected_left = 0;
            results_seen = 0;
            data_results = 0;
            dropped_bytes = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] == CMD_POP)
                begin
                    if (model_bytes.size() == 0)
                    begin
                        want.char_byte = 8'h00;
                        want.char_valid = 1'b0;
                    end
                    else
                    begin
                        want.char_byte = model_bytes.pop_front();
                        want.char_valid = 1'b1;
                    end
                    pending_chars.push_back(want);
                end
                else
                    predict_scancode(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                got.char_byte = m_axis_tdata;
                got.char_valid = m_axis_tuser[0];
                if (pending_chars.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none, got char_byte %02h char_valid %0b",
                             $time, got.char_byte, got.char_valid);
                    fail_count++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (want.char_valid)
                        data_results++;
                    if (got.char_byte !== want.char_byte)
                    begin
                        $display("%0t: char_byte expected %02h got %02h",
                                 $time, want.char_byte, got.char_byte);
                        fail_count++;
                    end
                    if (got.char_valid !== want.char_valid)
                    begin
                        $display("%0t: char_valid expected %0b got %0b",
                                 $time, want.char_valid, got.char_valid);
                        fail_count++;
                    end
                end
            end
            expected_left = pending_chars.size();
        end
    end

endmodule

[tb/scancode_to_ascii_fifo_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_core_tb
// Drives scancodes and pop commands into the translator under three idle
// mixes, with a queue overflow run and long output stalls; the checker module
// predicts every pop result and reports the failures.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_core_tb;

    import s2a_pkg::*;

    localparam logic [7:0] SC_ALT_MAKE  = 8'h38;
    localparam logic [7:0] SC_ALT_BREAK = 8'hB8;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] scan_byte
    logic [0:0] s_axis_tuser;   // [0] command
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] char_byte
    logic [0:0] m_axis_tuser;   // [0] char_valid

    int         fail_count;
    int         expected_left;
    int         results_seen;
    int         data_results;
    int         dropped_bytes;

    int         tx_idle_pct;
    int         rx_idle_pct;
    bit         rx_hold_req;
    int         items_sent;
    logic [7:0] directed_codes [29];

    scancode_to_ascii_fifo_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    scancode_to_ascii_fifo_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .expected_left (expected_left),
        .results_seen  (results_seen),
        .data_results  (data_results),
        .dropped_bytes (dropped_bytes)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout at %0t with %0d results outstanding", $time, expected_left);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_transfer(input logic cmd, input logic [7:0] code);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= code;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [7:0] random_scancode();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return 8'($urandom_range(1, 57));
        if (pick < 57)
        begin
            case ($urandom_range(0, 5))
                0:       return SC_LSHIFT_MAKE;
                1:       return SC_RSHIFT_MAKE;
                2:       return SC_LSHIFT_BREAK;
                3:       return SC_RSHIFT_BREAK;
                4:       return SC_CTRL_MAKE;
                default: return SC_CTRL_BREAK;
            endcase
        end
        if (pick < 67)
        begin
            case ($urandom_range(0, 6))
                0:       return SC_UP;
                1:       return SC_DOWN;
                2:       return SC_RIGHT;
                3:       return SC_LEFT;
                4:       return SC_HOME;
                5:       return SC_END;
                default: return SC_DELETE;
            endcase
        end
        if (pick < 85)
            return 8'h80 | 8'($urandom_range(0, 127));
        return 8'($urandom_range(0, 255));
    endfunction

    // Any of these codes queues exactly one byte whatever the modifiers are.
    function automatic logic [7:0] single_byte_code();
        logic [7:0] code;
        do
            code = 8'($urandom_range(1, 57));
        while (code == SC_CTRL_MAKE || code == SC_LSHIFT_MAKE ||
               code == SC_RSHIFT_MAKE || code == SC_ALT_MAKE);
        return code;
    endfunction

    task automatic run_mixed(input int count, input bit hold_output);
        int pop_pct;
        pop_pct = 50;
        if (hold_output)
            rx_hold_req = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if (!hold_output && i % 50 == 0)
                pop_pct = ((i / 50) % 3 == 0) ? 15 : (((i / 50) % 3 == 1) ? 45 : 75);
            if ($urandom_range(0, 99) < pop_pct)
                send_transfer(CMD_POP, 8'($urandom_range(0, 255)));
            else
                send_transfer(CMD_SCAN, random_scancode());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = CMD_SCAN;
        m_axis_tready = 1'b0;
        rx_hold_req = 1'b0;
        items_sent = 0;
        tx_idle_pct = 12;
        rx_idle_pct = 65;
        directed_codes = '{
            8'h1E, SC_LSHIFT_MAKE, 8'h1E, 8'h02, SC_LSHIFT_BREAK,
            SC_RSHIFT_MAKE, 8'h10, SC_RSHIFT_BREAK, SC_CTRL_MAKE, 8'h2C,
            8'h02, SC_LSHIFT_MAKE, 8'h1E, SC_LSHIFT_BREAK, SC_CTRL_BREAK,
            SC_UP, SC_DOWN, SC_RIGHT, SC_LEFT, SC_HOME,
            SC_END, SC_DELETE, SC_ALT_MAKE, SC_ALT_BREAK, 8'h00,
            8'h3A, 8'h7F, 8'hFF, 8'h39
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_transfer(CMD_POP, 8'hFF);
        foreach (directed_codes[i])
            send_transfer(CMD_SCAN, directed_codes[i]);
        repeat (32) send_transfer(CMD_POP, 8'($urandom_range(0, 255)));

        // Drain, fill to three free entries, then cut a delete sequence short.
        repeat (130) send_transfer(CMD_POP, 8'($urandom_range(0, 255)));
        repeat (124) send_transfer(CMD_SCAN, single_byte_code());
        send_transfer(CMD_SCAN, SC_DELETE);
        send_transfer(CMD_SCAN, single_byte_code());
        repeat (130) send_transfer(CMD_POP, 8'($urandom_range(0, 255)));

        run_mixed(150, 1'b1);
        run_mixed(200, 1'b0);

        tx_idle_pct = 65;
        rx_idle_pct = 12;
        run_mixed(150, 1'b1);
        run_mixed(200, 1'b0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_mixed(150, 1'b1);
        run_mixed(200, 1'b0);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d transfers: directed keys and modifiers, a queue overflow with a cut",
                 items_sent);
        $display("escape sequence, long output stalls; %0d pops checked, %0d with data, %0d dropped.",
                 results_seen, data_results, dropped_bytes);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
hdl/s2a_pkg.sv
hdl/s2a_xlate.sv
hdl/s2a_fifo.sv
hdl/scancode_to_ascii_fifo_core.sv
tb/scancode_to_ascii_fifo_checker.sv
tb/scancode_to_ascii_fifo_core_tb.sv
